@@ src/cnm_pkg.sv @@
// ---------------------------------------------------------------------------
// cnm_pkg
// Shared types, constants and helpers for the cartridge network mailbox.
// ---------------------------------------------------------------------------
package cnm_pkg;

    // buffer depth, a power of two from 16 to 256
    localparam int BUF_DEPTH = 256;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int CW        = $clog2(BUF_DEPTH + 1);

    localparam logic [3:0] MAX_PENDING_RST = 4'd5;

    localparam logic [15:0] HOT_MASK     = 16'h0FFF;
    localparam logic [15:0] HOT_TX       = 16'h0FF0;
    localparam logic [15:0] HOT_TX_SEND  = 16'h0FF1;
    localparam logic [15:0] HOT_RX       = 16'h0FF2;
    localparam logic [15:0] HOT_RX_COUNT = 16'h0FF3;

    localparam logic [2:0] KIND_BUS_READ  = 3'd0;
    localparam logic [2:0] KIND_BUS_WRITE = 3'd1;
    localparam logic [2:0] KIND_RSP_BYTE  = 3'd2;
    localparam logic [2:0] KIND_REQ_FAIL  = 3'd3;
    localparam logic [2:0] KIND_TX_FETCH  = 3'd4;

    typedef logic [AW-1:0] ptr_t;
    typedef logic [CW-1:0] fill_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic        response_last;
        logic [7:0]  fetch_index;
    } in_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] read_data;
        logic       send_start;
        logic [7:0] send_length;
        logic       send_dropped;
        logic [7:0] tx_byte;
    } out_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
    } status_t;

    function automatic ptr_t wrap_next(input ptr_t p);
        return (p == ptr_t'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // entries are written in order from zero, so a fill mark tracks them
    function automatic fill_t fill_next(input fill_t f, input ptr_t p);
        return (fill_t'(p) == f) ? f + 1'b1 : f;
    endfunction

endpackage

@@ src/cnm_ram.sv @@
// ---------------------------------------------------------------------------
// cnm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/cnm_ctrl.sv @@
// ---------------------------------------------------------------------------
// cnm_ctrl
// Sequencer: takes one item, waits for the buffer read, then commits it.
// ---------------------------------------------------------------------------
module cnm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cnm_pkg::status_t  status,
    output cnm_pkg::cmd_t     cmd
);

    cnm_pkg::state_t state_reg;
    cnm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cnm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            cnm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = cnm_pkg::ST_EXEC;
                end
            end
            cnm_pkg::ST_EXEC:
            begin
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = cnm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cnm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/cnm_dp.sv @@
// ---------------------------------------------------------------------------
// cnm_dp
// Datapath: buffers, pointers, pending count, result register.
// ---------------------------------------------------------------------------
module cnm_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  cnm_pkg::in_t      req_item,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output cnm_pkg::out_t     rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data,
    input  cnm_pkg::cmd_t     cmd,
    output cnm_pkg::status_t  status
);

    cnm_pkg::in_t   item_reg;
    cnm_pkg::out_t  out_reg;
    cnm_pkg::out_t  out_next;
    logic           out_valid_reg;
    logic           out_valid_next;

    cnm_pkg::ptr_t  rp_reg, rp_next;
    cnm_pkg::ptr_t  wp_reg, wp_next;
    cnm_pkg::ptr_t  tp_reg, tp_next;
    cnm_pkg::fill_t rx_fill_reg, rx_fill_next;
    cnm_pkg::fill_t tx_fill_reg, tx_fill_next;
    logic [3:0]     pend_reg, pend_next;
    logic [3:0]     max_pend_reg;

    logic           rx_we, tx_we;
    logic [7:0]     rx_rdata, tx_rdata;
    cnm_pkg::ptr_t  tx_raddr;
    cnm_pkg::ptr_t  tx_fidx;
    cnm_pkg::ptr_t  tp_adv;
    cnm_pkg::ptr_t  unread;
    logic [15:0]    hot;
    logic           rx_ok, tx_ok;

    assign cfg_ready        = 1'b1;
    assign rsp_valid        = out_valid_reg;
    assign rsp_item         = out_reg;
    assign status.slot_free = !out_valid_reg || rsp_ready;

    assign tx_raddr = req_item.fetch_index[cnm_pkg::AW-1:0];
    assign tx_fidx  = item_reg.fetch_index[cnm_pkg::AW-1:0];
    assign hot      = item_reg.address & cnm_pkg::HOT_MASK;
    assign tp_adv   = cnm_pkg::wrap_next(tp_reg);
    assign unread   = wp_reg - rp_reg;
    assign rx_ok    = cnm_pkg::fill_t'(rp_reg) < rx_fill_reg;
    assign tx_ok    = cnm_pkg::fill_t'(tx_fidx) < tx_fill_reg;

    cnm_ram #(.WIDTH(8), .DEPTH(cnm_pkg::BUF_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (wp_reg),
        .wdata (item_reg.data),
        .re    (cmd.capture),
        .raddr (rp_reg),
        .rdata (rx_rdata)
    );

    cnm_ram #(.WIDTH(8), .DEPTH(cnm_pkg::BUF_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tp_reg),
        .wdata (item_reg.data),
        .re    (cmd.capture),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        out_next     = '0;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        tp_next      = tp_reg;
        rx_fill_next = rx_fill_reg;
        tx_fill_next = tx_fill_reg;
        pend_next    = pend_reg;
        case (item_reg.kind)
            cnm_pkg::KIND_BUS_READ:
            begin
                if (hot == cnm_pkg::HOT_RX)
                begin
                    out_next.hit       = 1'b1;
                    out_next.read_data = rx_ok ? rx_rdata : 8'd0;
                    if (rp_reg != wp_reg)
                    begin
                        rp_next = cnm_pkg::wrap_next(rp_reg);
                    end
                end
                else if (hot == cnm_pkg::HOT_RX_COUNT)
                begin
                    out_next.hit       = 1'b1;
                    out_next.read_data = 8'(unread);
                end
            end
            cnm_pkg::KIND_BUS_WRITE:
            begin
                if (hot == cnm_pkg::HOT_TX || hot == cnm_pkg::HOT_TX_SEND)
                begin
                    out_next.hit = 1'b1;
                    tx_we        = cmd.commit;
                    tx_fill_next = cnm_pkg::fill_next(tx_fill_reg, tp_reg);
                    tp_next      = tp_adv;
                    if (hot == cnm_pkg::HOT_TX_SEND)
                    begin
                        if (pend_reg >= max_pend_reg)
                        begin
                            out_next.send_dropped = 1'b1;
                        end
                        else
                        begin
                            out_next.send_start  = 1'b1;
                            out_next.send_length = 8'(tp_adv);
                            pend_next            = pend_reg + 4'd1;
                        end
                        tp_next = '0;
                    end
                end
            end
            cnm_pkg::KIND_RSP_BYTE:
            begin
                rx_we        = cmd.commit;
                rx_fill_next = cnm_pkg::fill_next(rx_fill_reg, wp_reg);
                wp_next      = cnm_pkg::wrap_next(wp_reg);
                if (item_reg.response_last && pend_reg != 4'd0)
                begin
                    pend_next = pend_reg - 4'd1;
                end
            end
            cnm_pkg::KIND_REQ_FAIL:
            begin
                if (pend_reg != 4'd0)
                begin
                    pend_next = pend_reg - 4'd1;
                end
            end
            cnm_pkg::KIND_TX_FETCH:
            begin
                out_next.tx_byte = tx_ok ? tx_rdata : 8'd0;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            tp_reg        <= '0;
            rx_fill_reg   <= '0;
            tx_fill_reg   <= '0;
            pend_reg      <= '0;
            max_pend_reg  <= cnm_pkg::MAX_PENDING_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit)
            begin
                rp_reg      <= rp_next;
                wp_reg      <= wp_next;
                tp_reg      <= tp_next;
                rx_fill_reg <= rx_fill_next;
                tx_fill_reg <= tx_fill_next;
                pend_reg    <= pend_next;
            end
            if (cfg_valid)
            begin
                max_pend_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_item;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ src/cartridge_network_mailbox_top.sv @@
// ---------------------------------------------------------------------------
// cartridge_network_mailbox_top
// Mailbox behind four bus hotspots with a transmit buffer and receive ring.
//
// req_valid/req_ready carry one item (bus read, bus write, response byte,
// request failure or transmit byte fetch); every item yields exactly one
// item on rsp_valid/rsp_ready. cfg_valid/cfg_ready write max_pending.
// Timing: an item is taken in the idle state, where the item register and the
// buffer read data are registered; the result is loaded into the output
// register in the exec state once that register is free. A new item is not
// taken until the previous one is committed into the output register.
// A result waiting in the output register does not stop the next item from
// being taken; a stalled receiver holds the sequencer in its exec state and
// the second item in the item register until the output register frees up.
// Reset clears pointers, fill marks and pending count, and sets max_pending
// to 5; unwritten buffer entries read as zero, so no clearing pass is run.
// ---------------------------------------------------------------------------
module cartridge_network_mailbox_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cnm_pkg::in_t   req_item,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cnm_pkg::out_t  rsp_item,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [3:0]     cfg_data
);

    cnm_pkg::cmd_t    cmd;
    cnm_pkg::status_t status;

    cnm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cnm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ src/cnm_checker.sv @@
// ---------------------------------------------------------------------------
// cnm_checker
// Port-level checks for the mailbox, bound to the top level.
// ---------------------------------------------------------------------------
module cnm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input cnm_pkg::out_t  rsp_item,
    input logic           rsp_valid,
    input logic           rsp_ready
);

    // held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while previous in flight");

    a_start_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_item.send_start && rsp_item.send_dropped))
        else $error("send both started and dropped");

    a_send_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_item.send_start || rsp_item.send_dropped) |-> rsp_item.hit)
        else $error("send outcome without hotspot hit");

    a_fetch_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.tx_byte != 8'd0 |-> !rsp_item.hit && !rsp_item.send_start)
        else $error("fetch byte on a bus result");

endmodule

bind cartridge_network_mailbox_top cnm_checker u_cnm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_item  (rsp_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
);

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cartridge network mailbox. Bus reads and
// writes of the four hotspots, response bytes, failure reports and transmit
// fetches go in over a valid/ready channel in random bursts. A scoreboard
// keeps its own copy of the buffers, pointers and pending count, predicts
// one result item per accepted item and checks every returned field. The
// pending limit is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb;

    localparam int HOLD_CYCLES = 80;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    class mailbox_scoreboard_t;
        logic [7:0]     rx_ring [cnm_pkg::BUF_DEPTH];
        logic [7:0]     tx_store [cnm_pkg::BUF_DEPTH];
        cnm_pkg::ptr_t  rx_rd;
        cnm_pkg::ptr_t  rx_wr;
        cnm_pkg::ptr_t  tx_pos;
        logic [3:0]     pend;
        logic [3:0]     pend_limit;
        cnm_pkg::out_t  due_results [$];
        int             errors;

        function new();
            foreach (rx_ring[i])
            begin
                rx_ring[i]  = '0;
                tx_store[i] = '0;
            end
            rx_rd      = '0;
            rx_wr      = '0;
            tx_pos     = '0;
            pend       = '0;
            pend_limit = cnm_pkg::MAX_PENDING_RST;
            errors     = 0;
        endfunction

        function void set_limit(input logic [3:0] value);
            pend_limit = value;
        endfunction

        function int due_count();
            return due_results.size();
        endfunction

        function cnm_pkg::out_t mailbox_outcome(input cnm_pkg::in_t it);
            cnm_pkg::out_t r;
            logic [15:0]   hot;
            r   = '0;
            hot = it.address & cnm_pkg::HOT_MASK;
            case (it.kind)
                cnm_pkg::KIND_BUS_READ:
                begin
                    if (hot == cnm_pkg::HOT_RX)
                    begin
                        r.hit       = 1'b1;
                        r.read_data = rx_ring[rx_rd];
                        if (rx_rd != rx_wr)
                            rx_rd = rx_rd + 1'b1;
                    end
                    else if (hot == cnm_pkg::HOT_RX_COUNT)
                    begin
                        r.hit       = 1'b1;
                        r.read_data = 8'(cnm_pkg::ptr_t'(rx_wr - rx_rd));
                    end
                end
                cnm_pkg::KIND_BUS_WRITE:
                begin
                    if (hot == cnm_pkg::HOT_TX || hot == cnm_pkg::HOT_TX_SEND)
                    begin
                        r.hit            = 1'b1;
                        tx_store[tx_pos] = it.data;
                        tx_pos           = tx_pos + 1'b1;
                        if (hot == cnm_pkg::HOT_TX_SEND)
                        begin
                            if (pend >= pend_limit)
                                r.send_dropped = 1'b1;
                            else
                            begin
                                r.send_start  = 1'b1;
                                r.send_length = 8'(tx_pos);
                                pend          = pend + 1'b1;
                            end
                            tx_pos = '0;
                        end
                    end
                end
                cnm_pkg::KIND_RSP_BYTE:
                begin
                    rx_ring[rx_wr] = it.data;
                    rx_wr          = rx_wr + 1'b1;
                    if (it.response_last && pend != 0)
                        pend = pend - 1'b1;
                end
                cnm_pkg::KIND_REQ_FAIL:
                begin
                    if (pend != 0)
                        pend = pend - 1'b1;
                end
                cnm_pkg::KIND_TX_FETCH:
                    r.tx_byte = tx_store[cnm_pkg::ptr_t'(it.fetch_index)];
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(input cnm_pkg::in_t it);
            cnm_pkg::out_t want;
            want = mailbox_outcome(it);
            due_results.insert(due_results.size(), want);
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input cnm_pkg::out_t got);
            cnm_pkg::out_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result item %h with none expected", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("hit", 8'(want.hit), 8'(got.hit));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("send_start", 8'(want.send_start), 8'(got.send_start));
            compare_field("send_length", want.send_length, got.send_length);
            compare_field("send_dropped", 8'(want.send_dropped), 8'(got.send_dropped));
            compare_field("tx_byte", want.tx_byte, got.tx_byte);
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    cnm_pkg::in_t  req_item;
    logic          rsp_valid;
    logic          rsp_ready;
    cnm_pkg::out_t rsp_item;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [3:0]    cfg_data;

    mailbox_scoreboard_t mailbox_sb;
    int                  burst_left;
    int                  items_sent;
    logic                hold_off_go;

    cartridge_network_mailbox_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            mailbox_sb.check_result(rsp_item);
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : rsp_side
        rx_mode_t mode;
        int       mode_left;
        int       hold;
        logic     hold_done;
        rsp_ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_go && !hold_done)
            begin
                rsp_ready <= 1'b0;
                for (hold = 1; hold < HOLD_CYCLES; hold++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 60);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: rsp_ready <= 1'b1;
                    RX_COIN:   rsp_ready <= 1'($urandom);
                    RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_ready <= ~rsp_ready;
                endcase
            end
        end
    end

    function automatic cnm_pkg::in_t random_item();
        cnm_pkg::in_t it;
        it.kind          = 3'($urandom_range(0, 7));
        it.address       = 16'($urandom);
        it.data          = 8'($urandom);
        it.response_last = 1'($urandom);
        it.fetch_index   = 8'($urandom);
        return it;
    endfunction

    task automatic push_item(input cnm_pkg::in_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (!req_ready);
        mailbox_sb.note_item(it);
        items_sent++;
        burst_left--;
    endtask

    task automatic bus_read(input logic [15:0] hot);
        cnm_pkg::in_t it;
        it         = random_item();
        it.kind    = cnm_pkg::KIND_BUS_READ;
        it.address = (it.address & ~cnm_pkg::HOT_MASK) | hot;
        push_item(it);
    endtask

    task automatic bus_write(input logic [15:0] hot, input logic [7:0] value);
        cnm_pkg::in_t it;
        it         = random_item();
        it.kind    = cnm_pkg::KIND_BUS_WRITE;
        it.address = (it.address & ~cnm_pkg::HOT_MASK) | hot;
        it.data    = value;
        push_item(it);
    endtask

    task automatic rsp_byte(input logic [7:0] value, input logic last);
        cnm_pkg::in_t it;
        it               = random_item();
        it.kind          = cnm_pkg::KIND_RSP_BYTE;
        it.data          = value;
        it.response_last = last;
        push_item(it);
    endtask

    task automatic req_fail();
        cnm_pkg::in_t it;
        it      = random_item();
        it.kind = cnm_pkg::KIND_REQ_FAIL;
        push_item(it);
    endtask

    task automatic tx_fetch(input logic [7:0] index);
        cnm_pkg::in_t it;
        it             = random_item();
        it.kind        = cnm_pkg::KIND_TX_FETCH;
        it.fetch_index = index;
        push_item(it);
    endtask

    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (mailbox_sb.due_count() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        mailbox_sb.set_limit(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_mix(input int count);
        int stop;
        int k;
        int m;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    m = $urandom_range(0, 6);
                    for (k = 0; k < m; k++)
                        bus_write(cnm_pkg::HOT_TX, 8'($urandom));
                    bus_write(cnm_pkg::HOT_TX_SEND, 8'($urandom));
                end
                3, 4:
                begin
                    m = $urandom_range(1, 8);
                    for (k = 1; k <= m; k++)
                        rsp_byte(8'($urandom), k == m);
                end
                5:
                begin
                    m = $urandom_range(1, 6);
                    for (k = 0; k < m; k++)
                        bus_read(cnm_pkg::HOT_RX);
                end
                6:
                begin
                    m = $urandom_range(1, 4);
                    for (k = 0; k < m; k++)
                        tx_fetch(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 15)));
                end
                7: req_fail();
                8: bus_read(cnm_pkg::HOT_RX_COUNT);
                default: push_item(random_item());
            endcase
        end
    endtask

    initial
    begin : stimulus
        cnm_pkg::in_t item;
        logic [3:0]   limits [6];
        int           p;
        int           k;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_item    = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        hold_off_go = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        mailbox_sb  = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // empty ring, wrong direction and address extremes
        bus_read(cnm_pkg::HOT_RX);
        bus_read(cnm_pkg::HOT_RX_COUNT);
        bus_read(cnm_pkg::HOT_TX);
        bus_read(cnm_pkg::HOT_TX_SEND);
        bus_write(cnm_pkg::HOT_RX, 8'hFF);
        bus_write(cnm_pkg::HOT_RX_COUNT, 8'h00);
        item         = random_item();
        item.kind    = cnm_pkg::KIND_BUS_READ;
        item.address = '0;
        push_item(item);
        item.kind    = cnm_pkg::KIND_BUS_WRITE;
        item.address = '1;
        push_item(item);

        // short message, then fetch it back
        bus_write(cnm_pkg::HOT_TX, 8'hFF);
        bus_write(cnm_pkg::HOT_TX, 8'h00);
        bus_write(cnm_pkg::HOT_TX_SEND, 8'hA5);
        tx_fetch(8'd0);
        tx_fetch(8'd2);
        tx_fetch(8'hFF);

        // response retires the send, then retire with nothing pending
        rsp_byte(8'h5A, 1'b0);
        rsp_byte(8'hC3, 1'b1);
        req_fail();
        rsp_byte(8'h00, 1'b1);
        bus_read(cnm_pkg::HOT_RX_COUNT);
        repeat (4) bus_read(cnm_pkg::HOT_RX);

        // spare kinds with every field set
        for (k = 1; k <= 3; k++)
        begin
            item      = '1;
            item.kind = cnm_pkg::KIND_TX_FETCH + 3'(k);
            push_item(item);
        end

        // reach the reset pending limit, last one dropped
        repeat (6) bus_write(cnm_pkg::HOT_TX_SEND, 8'($urandom));

        limits = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'($urandom_range(0, 15))};
        for (p = 0; p < 6; p++)
        begin
            settle();
            cfg_write(limits[p]);
            if (p == 2)
            begin
                // receive overflow while the receiver holds off
                hold_off_go = 1'b1;
                for (k = 0; k < 260; k++)
                begin
                    rsp_byte(8'($urandom), $urandom_range(0, 15) == 0);
                    if (k % 64 == 63)
                        bus_read(cnm_pkg::HOT_RX_COUNT);
                end
                repeat (6) bus_read(cnm_pkg::HOT_RX);
                bus_read(cnm_pkg::HOT_RX_COUNT);
            end
            if (p == 3)
            begin
                // transmit position wraps, send length comes out zero
                repeat (255) bus_write(cnm_pkg::HOT_TX, 8'($urandom));
                bus_write(cnm_pkg::HOT_TX_SEND, 8'($urandom));
                repeat (4) tx_fetch(8'($urandom));
            end
            run_mix(5);
        end

        settle();
        if (mailbox_sb.errors == 0 && mailbox_sb.due_count() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
